[src/pcld_pkg.sv]
// Shared types, constants and lookup functions for the prefixed command line decoder.
// Depends on nothing; every other source file refers to it by scoped names.
package pcld_pkg;

	localparam int LINE_DEPTH = 64;
	localparam int ADDR_W = $clog2(LINE_DEPTH);
	localparam int CNT_W = $clog2(LINE_DEPTH + 1);
	localparam int IDLE_W = 16;
	localparam int CODE_W = 4;
	localparam int NUM_WORDS = 13;
	localparam int MAX_WORD_LEN = 7;
	localparam int WLEN_W = 3;
	localparam int PREFIX_LEN = 4;
	localparam int TEXT_START = 5;

	localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [IDLE_W-1:0] IDLE_MAX = 16'hFFFF;

	localparam logic OPC_BYTE = 1'b0;
	localparam logic OPC_TICK = 1'b1;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_ARG = 1'b1;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	localparam logic [CODE_W-1:0] CMD_ST = 4'd0;
	localparam logic [CODE_W-1:0] CMD_GT = 4'd1;
	localparam logic [CODE_W-1:0] CMD_SA = 4'd2;
	localparam logic [CODE_W-1:0] CMD_GA = 4'd3;
	localparam logic [CODE_W-1:0] CMD_EA = 4'd4;
	localparam logic [CODE_W-1:0] CMD_TA = 4'd5;
	localparam logic [CODE_W-1:0] CMD_SSD = 4'd6;
	localparam logic [CODE_W-1:0] CMD_GSD = 4'd7;
	localparam logic [CODE_W-1:0] CMD_SB = 4'd8;
	localparam logic [CODE_W-1:0] CMD_GB = 4'd9;
	localparam logic [CODE_W-1:0] CMD_SFF = 4'd10;
	localparam logic [CODE_W-1:0] CMD_SFS = 4'd11;
	localparam logic [CODE_W-1:0] CMD_CONNECT = 4'd12;
	localparam logic [CODE_W-1:0] CMD_INVALID = 4'd13;

	// Request from the byte ingest side to the line engine.
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              start;
		logic [CNT_W-1:0]  length;
	} pcld_req_t;

	// Command words, left-justified in 7 characters.
	function automatic logic [8*MAX_WORD_LEN-1:0] word_str(input logic [CODE_W-1:0] w);
		logic [8*MAX_WORD_LEN-1:0] s;
		case (w)
			CMD_ST:      s = {"st", 40'd0};
			CMD_GT:      s = {"gt", 40'd0};
			CMD_SA:      s = {"sa", 40'd0};
			CMD_GA:      s = {"ga", 40'd0};
			CMD_EA:      s = {"ea", 40'd0};
			CMD_TA:      s = {"ta", 40'd0};
			CMD_SSD:     s = {"ssd", 32'd0};
			CMD_GSD:     s = {"gsd", 32'd0};
			CMD_SB:      s = {"sb", 40'd0};
			CMD_GB:      s = {"gb", 40'd0};
			CMD_SFF:     s = {"sff", 32'd0};
			CMD_SFS:     s = {"sfs", 32'd0};
			CMD_CONNECT: s = "connect";
			default:     s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [WLEN_W-1:0] word_len(input logic [CODE_W-1:0] w);
		logic [WLEN_W-1:0] n;
		case (w)
			CMD_SSD, CMD_GSD, CMD_SFF, CMD_SFS: n = 3'd3;
			CMD_CONNECT:                        n = 3'd7;
			default:                            n = 3'd2;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = "E";
			2'd1:    c = "S";
			2'd2:    c = "P";
			default: c = ":";
		endcase
		return c;
	endfunction

endpackage

[src/pcld_ingest.sv]
// Input side of the decoder: fill count, idle tick counter and timeout register.
// Uses pcld_pkg; drives store writes and line-finish requests to pcld_engine.
module pcld_ingest (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [15:0]              cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     opcode,
	input  logic [7:0]               rx_byte,
	input  logic                     busy,
	output pcld_pkg::pcld_req_t      req
);

	logic [pcld_pkg::CNT_W-1:0]  fill_q, fill_d;
	logic [pcld_pkg::IDLE_W-1:0] idle_q, idle_d, idle_inc;
	logic [pcld_pkg::IDLE_W-1:0] timeout_q;
	logic                        acc;

	assign in_ready = !busy;
	assign acc = in_valid && !busy;
	assign idle_inc = (idle_q == pcld_pkg::IDLE_MAX) ? idle_q : idle_q + 16'd1;

	always_comb begin
		fill_d = fill_q;
		idle_d = idle_q;
		req = '0;
		req.wr_addr = fill_q[pcld_pkg::ADDR_W-1:0];
		req.wr_data = rx_byte;
		req.length = fill_q;
		if (acc) begin
			if (opcode == pcld_pkg::OPC_TICK) begin
				idle_d = idle_inc;
				if (fill_q != '0 && idle_inc >= timeout_q) begin
					fill_d = '0;
				end
			end else begin
				idle_d = '0;
				if (rx_byte == pcld_pkg::CHAR_LF) begin
					req.start = 1'b1;
					fill_d = '0;
				end else if (rx_byte != pcld_pkg::CHAR_CR &&
						fill_q < pcld_pkg::CNT_W'(pcld_pkg::LINE_DEPTH)) begin
					req.wr_en = 1'b1;
					fill_d = fill_q + pcld_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idle_q <= '0;
			timeout_q <= pcld_pkg::TIMEOUT_RESET;
		end else begin
			fill_q <= fill_d;
			idle_q <= idle_d;
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
		end
	end

endmodule

[src/pcld_engine.sv]
// Line store memory with the scan, match and emit sequencer and the output register.
// Uses pcld_pkg; fed by pcld_ingest through a pcld_req_t request.
module pcld_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcld_pkg::pcld_req_t           req,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          item_kind,
	output logic [pcld_pkg::CODE_W-1:0]   command_code,
	output logic [7:0]                    arg_byte,
	output logic                          last
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EV   = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_HDR  = 3'd4;
	localparam logic [2:0] S_ERD  = 3'd5;
	localparam logic [2:0] S_EDAT = 3'd6;

	localparam int CW = pcld_pkg::CNT_W;
	localparam int NW = pcld_pkg::NUM_WORDS;

	logic [7:0] mem [pcld_pkg::LINE_DEPTH];

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] len_q, len_d, pos_q, pos_d, te_q, te_d, space_q, space_d, ptr_q, ptr_d;
	logic          space_found_q, space_found_d;
	logic [NW-1:0] cand_q, cand_d, cand_upd;
	logic [pcld_pkg::CODE_W-1:0] code_q, code_d, code_fin;
	logic          hdr_last_q, hdr_last_d;
	logic          rd_en;
	logic [pcld_pkg::ADDR_W-1:0] rd_addr;
	logic [7:0]    rd_data_q;
	logic          out_valid_q, out_valid_d;
	logic          kind_q, last_q;
	logic [pcld_pkg::CODE_W-1:0] ocode_q;
	logic [7:0]    obyte_q;
	logic          load, ld_kind, ld_last;
	logic [7:0]    ld_byte;
	logic          slot_free;
	logic [CW-1:0] pos_nx, ptr_nx, j_w, space_eff, word_len_c, arg_start;

	assign pos_nx = pos_q + CW'(1);
	assign ptr_nx = ptr_q + CW'(1);
	assign j_w = pos_q - CW'(pcld_pkg::TEXT_START);
	assign slot_free = !out_valid_q || out_ready;

	// One character of the first word narrows the set of candidate command words.
	always_comb begin
		logic [8*pcld_pkg::MAX_WORD_LEN-1:0] ws;
		logic [7:0] wc;
		for (int w = 0; w < NW; w++) begin
			ws = pcld_pkg::word_str(pcld_pkg::CODE_W'(w));
			wc = ws[8*(pcld_pkg::MAX_WORD_LEN-1-int'(j_w[pcld_pkg::WLEN_W-1:0])) +: 8];
			cand_upd[w] = cand_q[w] && (j_w < CW'(pcld_pkg::MAX_WORD_LEN)) &&
				(j_w[pcld_pkg::WLEN_W-1:0] < pcld_pkg::word_len(pcld_pkg::CODE_W'(w))) &&
				(wc == rd_data_q);
		end
	end

	// End of scan: a surviving candidate must also have the right length.
	always_comb begin
		space_eff = space_found_q ? space_q : te_q;
		word_len_c = space_eff - CW'(pcld_pkg::TEXT_START);
		code_fin = pcld_pkg::CMD_INVALID;
		for (int w = NW - 1; w >= 0; w--) begin
			if (cand_q[w] &&
					word_len_c == CW'(pcld_pkg::word_len(pcld_pkg::CODE_W'(w)))) begin
				code_fin = pcld_pkg::CODE_W'(w);
			end
		end
		if (code_fin == pcld_pkg::CMD_INVALID) begin
			arg_start = CW'(pcld_pkg::TEXT_START);
		end else if (space_found_q) begin
			arg_start = space_q + CW'(1);
		end else begin
			arg_start = te_q;
		end
	end

	always_comb begin
		state_d = state_q;
		len_d = len_q;
		pos_d = pos_q;
		te_d = te_q;
		space_d = space_q;
		space_found_d = space_found_q;
		cand_d = cand_q;
		code_d = code_q;
		ptr_d = ptr_q;
		hdr_last_d = hdr_last_q;
		rd_en = 1'b0;
		rd_addr = ptr_q[pcld_pkg::ADDR_W-1:0];
		load = 1'b0;
		ld_kind = pcld_pkg::KIND_HEADER;
		ld_byte = '0;
		ld_last = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req.start && req.length >= CW'(pcld_pkg::PREFIX_LEN)) begin
					len_d = req.length;
					pos_d = '0;
					space_found_d = 1'b0;
					cand_d = '1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				rd_en = 1'b1;
				rd_addr = pos_q[pcld_pkg::ADDR_W-1:0];
				state_d = S_EV;
			end
			S_EV: begin
				if (pos_q < CW'(pcld_pkg::PREFIX_LEN)) begin
					if (rd_data_q != pcld_pkg::prefix_char(pos_q[1:0])) begin
						state_d = S_IDLE;
					end else if (pos_q == CW'(pcld_pkg::PREFIX_LEN - 1)) begin
						// The character after the prefix is skipped.
						pos_d = CW'(pcld_pkg::TEXT_START);
						state_d = (len_q > CW'(pcld_pkg::TEXT_START)) ? S_RD : S_IDLE;
					end else begin
						pos_d = pos_nx;
						state_d = S_RD;
					end
				end else if (rd_data_q == pcld_pkg::CHAR_NUL) begin
					te_d = pos_q;
					state_d = (pos_q == CW'(pcld_pkg::TEXT_START)) ? S_IDLE : S_FIN;
				end else begin
					if (!space_found_q) begin
						if (rd_data_q == pcld_pkg::CHAR_SPACE) begin
							space_found_d = 1'b1;
							space_d = pos_q;
						end else begin
							cand_d = cand_upd;
						end
					end
					if (pos_nx >= len_q) begin
						te_d = len_q;
						state_d = S_FIN;
					end else begin
						pos_d = pos_nx;
						state_d = S_RD;
					end
				end
			end
			S_FIN: begin
				code_d = code_fin;
				ptr_d = arg_start;
				hdr_last_d = (arg_start >= te_q);
				state_d = S_HDR;
			end
			S_HDR: begin
				if (slot_free) begin
					load = 1'b1;
					ld_last = hdr_last_q;
					state_d = hdr_last_q ? S_IDLE : S_ERD;
				end
			end
			S_ERD: begin
				rd_en = 1'b1;
				state_d = S_EDAT;
			end
			S_EDAT: begin
				if (slot_free) begin
					load = 1'b1;
					ld_kind = pcld_pkg::KIND_ARG;
					ld_byte = rd_data_q;
					ld_last = (ptr_nx == te_q);
					if (ptr_nx == te_q) begin
						state_d = S_IDLE;
					end else begin
						ptr_d = ptr_nx;
						state_d = S_ERD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	// Line store: one write port from the ingest side, one registered read port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		len_q <= len_d;
		pos_q <= pos_d;
		te_q <= te_d;
		space_q <= space_d;
		space_found_q <= space_found_d;
		cand_q <= cand_d;
		code_q <= code_d;
		ptr_q <= ptr_d;
		hdr_last_q <= hdr_last_d;
		if (load) begin
			kind_q <= ld_kind;
			ocode_q <= code_q;
			obyte_q <= ld_byte;
			last_q <= ld_last;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign item_kind = kind_q;
	assign command_code = ocode_q;
	assign arg_byte = obyte_q;
	assign last = last_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == S_IDLE)
		else $error("line finish request while the engine is busy");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> state_q == S_IDLE)
		else $error("store write during a line scan or emit");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> (pos_q < len_q && pos_q != CW'(pcld_pkg::PREFIX_LEN)))
		else $error("scan read outside the stored line");
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERD || state_q == S_EDAT) |-> ptr_q < te_q)
		else $error("argument read beyond the end of the text");
`endif

endmodule

[src/prefixed_command_line_decoder_top.sv]
// Usage:
// The input channel (in_valid/in_ready, opcode, rx_byte) carries one request per
// received byte (opcode 0) or per millisecond tick (opcode 1). The output channel
// (out_valid/out_ready) returns a command header followed by its argument bytes,
// with last set on the final result of the command. cfg_wr_en/cfg_wr_data write
// the 16-bit idle timeout in ticks; write it only while no line is being decoded.
// A byte or tick request other than a newline gives no result. A newline
// starts a decode that holds in_ready low: the single read port of the line
// store is walked one stored byte at a time, each byte read (S_RD) and then
// checked (S_EV), before the header is presented; each argument byte is then
// read again (S_ERD) and presented (S_EDAT), one byte after the other.
// A result waiting in the output register does not block new byte requests; a
// stalled receiver only holds the decode at its next result.
// Reset clears the fill count, the idle counter and the output valid, and loads
// a timeout of 1000 ticks. The line store itself is not cleared.
// Files: uses pcld_pkg, pcld_ingest and pcld_engine.
module prefixed_command_line_decoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [15:0]                 cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        item_kind,
	output logic [pcld_pkg::CODE_W-1:0] command_code,
	output logic [7:0]                  arg_byte,
	output logic                        last
);

	pcld_pkg::pcld_req_t req;
	logic                busy;

	pcld_ingest u_ingest (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.rx_byte     (rx_byte),
		.busy        (busy),
		.req         (req)
	);

	pcld_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.item_kind    (item_kind),
		.command_code (command_code),
		.arg_byte     (arg_byte),
		.last         (last)
	);

endmodule

[sim/command_decode_checker.sv]
// Scoreboard for the prefixed command line decoder: tracks the line store, the idle
// counter and the timeout register, predicts results and compares them in order.
// Depends on pcld_pkg for widths, character codes and command codes.
`timescale 1ns / 100ps

module command_decode_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [15:0]                 cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        opcode,
	input  logic [7:0]                  rx_byte,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        item_kind,
	input  logic [pcld_pkg::CODE_W-1:0] command_code,
	input  logic [7:0]                  arg_byte,
	input  logic                        last,
	output int                          pending_count,
	output int                          fail_count
);

	typedef struct packed {
		logic                        kind;
		logic [pcld_pkg::CODE_W-1:0] code;
		logic [7:0]                  data;
		logic                        last;
	} cmd_result_t;

	// Listed in command code order, starting at CMD_ST.
	string cmd_words [pcld_pkg::NUM_WORDS] = '{"st", "gt", "sa", "ga", "ea", "ta", "ssd",
		"gsd", "sb", "gb", "sff", "sfs", "connect"};

	logic [7:0]  line_store [pcld_pkg::LINE_DEPTH];
	int          fill_count;
	logic [15:0] idle_ticks;
	logic [15:0] idle_timeout;
	cmd_result_t awaited_results [$];

	function automatic bit word_at_text(input int w, input int len);
		int i;
		if (cmd_words[w].len() != len)
			return 1'b0;
		for (i = 0; i < len; i++)
			if (line_store[pcld_pkg::TEXT_START + i] != 8'(cmd_words[w][i]))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void push_result(input logic kind,
			input logic [pcld_pkg::CODE_W-1:0] code,
			input logic [7:0] data, input logic is_last);
		cmd_result_t r;
		r.kind = kind;
		r.code = code;
		r.data = data;
		r.last = is_last;
		awaited_results.push_back(r);
	endfunction

	task automatic decode_line();
		int length, text_end, space_at, arg_start, w, i;
		logic [pcld_pkg::CODE_W-1:0] code;
		length = fill_count;
		fill_count = 0;
		if (length < pcld_pkg::PREFIX_LEN)
			return;
		if ({line_store[0], line_store[1], line_store[2], line_store[3]} != "ESP:")
			return;
		// The text starts after the skipped fifth byte and stops at a zero byte.
		text_end = pcld_pkg::TEXT_START;
		while (text_end < length && line_store[text_end] != pcld_pkg::CHAR_NUL)
			text_end++;
		if (text_end <= pcld_pkg::TEXT_START)
			return;
		space_at = pcld_pkg::TEXT_START;
		while (space_at < text_end && line_store[space_at] != pcld_pkg::CHAR_SPACE)
			space_at++;
		code = pcld_pkg::CMD_INVALID;
		for (w = 0; w < pcld_pkg::NUM_WORDS && code == pcld_pkg::CMD_INVALID; w++)
			if (word_at_text(w, space_at - pcld_pkg::TEXT_START))
				code = pcld_pkg::CMD_ST + pcld_pkg::CODE_W'(w);
		// An unknown word hands back the whole text as arguments.
		if (code == pcld_pkg::CMD_INVALID)
			arg_start = pcld_pkg::TEXT_START;
		else if (space_at < text_end)
			arg_start = space_at + 1;
		else
			arg_start = text_end;
		push_result(pcld_pkg::KIND_HEADER, code, pcld_pkg::CHAR_NUL, arg_start >= text_end);
		for (i = arg_start; i < text_end; i++)
			push_result(pcld_pkg::KIND_ARG, code, line_store[i], i + 1 == text_end);
	endtask

	task automatic apply_request(input logic op, input logic [7:0] ch);
		if (op == pcld_pkg::OPC_TICK) begin
			if (idle_ticks != pcld_pkg::IDLE_MAX)
				idle_ticks++;
			if (fill_count != 0 && idle_ticks >= idle_timeout)
				fill_count = 0;
		end else begin
			idle_ticks = '0;
			if (ch == pcld_pkg::CHAR_LF)
				decode_line();
			else if (ch != pcld_pkg::CHAR_CR && fill_count < pcld_pkg::LINE_DEPTH) begin
				line_store[fill_count] = ch;
				fill_count++;
			end
		end
	endtask

	task automatic check_result();
		cmd_result_t want;
		if (awaited_results.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected result, expected none,", $time,
				" got kind %0d code %0d byte 0x%02h last %0d",
				item_kind, command_code, arg_byte, last);
			return;
		end
		want = awaited_results.pop_front();
		if (item_kind !== want.kind || command_code !== want.code ||
				arg_byte !== want.data || last !== want.last) begin
			fail_count++;
			$display("%0t: result mismatch, expected kind %0d code %0d byte 0x%02h last %0d,",
				$time, want.kind, want.code, want.data, want.last,
				" got kind %0d code %0d byte 0x%02h last %0d",
				item_kind, command_code, arg_byte, last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count = 0;
			idle_ticks = '0;
			idle_timeout = pcld_pkg::TIMEOUT_RESET;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (cfg_wr_en)
				idle_timeout = cfg_wr_data;
			if (in_valid && in_ready)
				apply_request(opcode, rx_byte);
		end
		pending_count = awaited_results.size();
	end

endmodule

[sim/tb_top.sv]
// Top of the decoder testbench: clock, reset, byte and tick requests, timeout writes,
// receiver stalls and the verdict. Depends on pcld_pkg, the decoder top and
// command_decode_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 300;
	localparam int ITEM_GOAL = 115;
	localparam int LINE_ANY = 0;
	localparam int LINE_LONG = 2;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic [15:0]                 cfg_wr_data;
	logic                        in_valid;
	logic                        in_ready;
	logic                        opcode;
	logic [7:0]                  rx_byte;
	logic                        out_valid;
	logic                        out_ready;
	logic                        item_kind;
	logic [pcld_pkg::CODE_W-1:0] command_code;
	logic [7:0]                  arg_byte;
	logic                        last;

	int pending_count;
	int fail_count;
	int cycle_count;
	int sent_count;
	int calm_tx;
	int calm_rx;
	bit tick_noise;
	logic [7:0] line_bytes [$];

	string cmd_words [pcld_pkg::NUM_WORDS] = '{"st", "gt", "sa", "ga", "ea", "ta", "ssd",
		"gsd", "sb", "gb", "sff", "sfs", "connect"};

	prefixed_command_line_decoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.item_kind   (item_kind),
		.command_code(command_code),
		.arg_byte    (arg_byte),
		.last        (last)
	);

	command_decode_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.item_kind    (item_kind),
		.command_code (command_code),
		.arg_byte     (arg_byte),
		.last         (last),
		.pending_count(pending_count),
		.fail_count   (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones, and now and then a stretch with none.
	function automatic int pick_gap(input bit rx_side);
		int r;
		if (rx_side ? calm_rx > 0 : calm_tx > 0) begin
			if (rx_side)
				calm_rx--;
			else
				calm_tx--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			if (rx_side)
				calm_rx = $urandom_range(10, 40);
			else
				calm_tx = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (b == pcld_pkg::CHAR_CR || b == pcld_pkg::CHAR_LF)
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	function automatic logic [7:0] arg_char();
		int r;
		logic [7:0] b;
		r = $urandom_range(0, 19);
		b = text_byte();
		if (r == 0)
			return pcld_pkg::CHAR_NUL;
		if (r < 5)
			return (b == pcld_pkg::CHAR_NUL) ? 8'hFF : b;
		return 8'($urandom_range(32, 126));
	endfunction

	task automatic send_req(input logic op, input logic [7:0] ch);
		int gap;
		gap = pick_gap(1'b0);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		rx_byte <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_req(pcld_pkg::OPC_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_req(pcld_pkg::OPC_BYTE, 8'(s[i]));
	endtask

	task automatic push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			line_bytes.push_back(8'(s[i]));
	endtask

	// Mostly well-formed command lines with random content; the rest is raw noise,
	// damaged prefixes and lines that overrun the store.
	task automatic send_random_line(input int word_sel, input int mode);
		int kind, n, i;
		kind = (mode == LINE_ANY) ? $urandom_range(0, 99) : 0;
		line_bytes.delete();
		if (mode == LINE_LONG || kind >= 96) begin
			push_text("ESP: ta ");
			n = $urandom_range(57, 60);
			repeat (n) line_bytes.push_back(8'($urandom_range(32, 126)));
			line_bytes.push_back(pcld_pkg::CHAR_LF);
		end else if (kind < 70) begin
			push_text("ESP:");
			line_bytes.push_back(text_byte());
			if (word_sel < pcld_pkg::NUM_WORDS)
				push_text(cmd_words[word_sel]);
			else begin
				n = $urandom_range(1, 4);
				repeat (n) line_bytes.push_back(8'($urandom_range("a", "z")));
			end
			if ($urandom_range(0, 9) < 7) begin
				line_bytes.push_back(pcld_pkg::CHAR_SPACE);
				n = $urandom_range(0, 8);
				repeat (n) line_bytes.push_back(arg_char());
			end
			line_bytes.push_back(pcld_pkg::CHAR_LF);
		end else if (kind < 85) begin
			n = $urandom_range(1, 12);
			repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			push_text("ESP: gb 7");
			if ($urandom_range(0, 1)) begin
				n = $urandom_range(0, 3);
				line_bytes[n] = line_bytes[n] ^ 8'($urandom_range(1, 255));
			end else begin
				n = $urandom_range(1, 3);
				while (line_bytes.size() > n)
					void'(line_bytes.pop_back());
			end
			line_bytes.push_back(pcld_pkg::CHAR_LF);
		end
		for (i = 0; i < line_bytes.size(); i++) begin
			if (tick_noise && $urandom_range(0, 15) == 0)
				send_ticks($urandom_range(1, 4));
			send_req(pcld_pkg::OPC_BYTE, line_bytes[i]);
		end
	endtask

	// A newline that yields nothing can still be decoding when the last result is in,
	// so the settle time covers a full-store decode.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] ticks);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ticks;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int g;
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			g = pick_gap(1'b1);
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		opcode = pcld_pkg::OPC_BYTE;
		rx_byte = '0;
		tick_noise = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed lines under the reset timeout.
		send_text("ESP:#st 9");
		send_req(pcld_pkg::OPC_BYTE, pcld_pkg::CHAR_CR);
		send_text("\n");
		send_text("ESP: zz ");
		send_req(pcld_pkg::OPC_BYTE, pcld_pkg::CHAR_NUL);
		send_text("x\n");
		send_text("ESP: s");
		send_ticks(2);
		send_text("fs 1\n");

		// A zero timeout drops a partial line on the first tick.
		write_timeout('0);
		send_text("ESP: ea");
		send_ticks(1);
		send_text("\n");

		// A short timeout, then a line that overruns the store.
		write_timeout(16'($urandom_range(1, 6)));
		send_random_line(0, LINE_LONG);

		// Random lines; stray ticks sometimes clear a partial line.
		tick_noise = 1'b1;
		while (sent_count < ITEM_GOAL)
			send_random_line($urandom_range(0, pcld_pkg::NUM_WORDS), LINE_ANY);

		drain();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[prefixed_command_line_decoder_top.f]
src/pcld_pkg.sv
src/pcld_ingest.sv
src/pcld_engine.sv
src/prefixed_command_line_decoder_top.sv
sim/command_decode_checker.sv
sim/tb_top.sv
